### src/cdq_pkg.sv
// Package for the circular deque: shared constants and the operation codes.
// Used by circular_deque_top and its testbench.
`default_nettype none
package cdq_pkg;

  localparam int RING_SLOTS_DEF = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int OP_W    = 3;
  localparam int IO_W    = 32;
  localparam int CAP_W   = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd15;

  typedef enum logic [OP_W-1:0] {
    OP_PEEK       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_t;

endpackage
`default_nettype wire

### src/circular_deque_top.sv
// Circular deque top level: pointer control around the cdq_ram ring storage.
// Depends on cdq_pkg and cdq_ram.
// A result strobes on out_valid in the cycle after its request is taken.
// Throughput: one request per cycle; busy stays low, the ring is read and
// written in the same cycle the request is taken. The receiver cannot stall.
// Reset (rst_n low, synchronous): pointers to 0, capacity to 15, no result.
`default_nettype none
module circular_deque_top #(
  parameter int RING_SLOTS = cdq_pkg::RING_SLOTS_DEF,
  parameter int VALUE_BITS = cdq_pkg::VALUE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [cdq_pkg::OP_W-1:0]  in_operation,
  input  wire logic signed [cdq_pkg::IO_W-1:0] in_push_value,
  input  wire logic                      cfg_we,
  input  wire logic [cdq_pkg::CAP_W-1:0] cfg_capacity,
  output logic                           out_valid,
  output logic                           out_accepted,
  output logic signed [cdq_pkg::IO_W-1:0] out_front_value,
  output logic signed [cdq_pkg::IO_W-1:0] out_rear_value,
  output logic                           out_now_empty,
  output logic                           out_now_full
);

  localparam int PTR_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int CNT_W = $clog2(RING_SLOTS + 1);
  localparam int SW    = (CNT_W > cdq_pkg::CAP_W + 1) ? CNT_W : cdq_pkg::CAP_W + 1;
  localparam logic [SW-1:0] SLOTS_MAX = SW'(RING_SLOTS);

  logic [cdq_pkg::CAP_W-1:0] cap_r;
  logic [PTR_W-1:0]          front_r, front_nxt;
  logic [PTR_W-1:0]          back_r, back_nxt;
  logic                      valid_r, accepted_r, empty_r, full_r;
  logic                      ok_nxt, empty_nxt, full_nxt;

  logic [SW-1:0]    slots_raw;
  logic [PTR_W-1:0] last;
  logic             accept;
  logic             empty_cur, full_cur;
  logic             we;
  logic [PTR_W-1:0] waddr;
  logic [PTR_W-1:0] rear_addr;
  logic [VALUE_BITS-1:0] wdata;
  logic [VALUE_BITS-1:0] rd_front, rd_rear;
  logic [63:0]      front_ext, rear_ext;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p,
                                                input logic [PTR_W-1:0] lst);
    return (p == lst) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p,
                                                input logic [PTR_W-1:0] lst);
    return (p == '0) ? lst : PTR_W'(p - 1'b1);
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    slots_raw = SW'(cap_r) + SW'(1);
    if (slots_raw > SLOTS_MAX) begin
      slots_raw = SLOTS_MAX;
    end
    last = PTR_W'(slots_raw - SW'(1));
  end

  assign empty_cur = (front_r == back_r);
  assign full_cur  = (wrap_inc(back_r, last) == front_r);

  assign wdata = VALUE_BITS'({{32{in_push_value[cdq_pkg::IO_W-1]}}, in_push_value});

  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    ok_nxt    = 1'b0;
    we        = 1'b0;
    waddr     = back_r;
    unique case (in_operation)
      cdq_pkg::OP_PEEK: begin
        ok_nxt = 1'b1;
      end
      cdq_pkg::OP_PUSH_FRONT: begin
        if (!full_cur) begin
          front_nxt = wrap_dec(front_r, last);
          waddr     = front_nxt;
          we        = accept;
          ok_nxt    = 1'b1;
        end
      end
      cdq_pkg::OP_PUSH_BACK: begin
        if (!full_cur) begin
          waddr    = back_r;
          back_nxt = wrap_inc(back_r, last);
          we       = accept;
          ok_nxt   = 1'b1;
        end
      end
      cdq_pkg::OP_POP_FRONT: begin
        if (!empty_cur) begin
          front_nxt = wrap_inc(front_r, last);
          ok_nxt    = 1'b1;
        end
      end
      cdq_pkg::OP_POP_BACK: begin
        if (!empty_cur) begin
          back_nxt = wrap_dec(back_r, last);
          ok_nxt   = 1'b1;
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
    empty_nxt = (front_nxt == back_nxt);
    full_nxt  = (wrap_inc(back_nxt, last) == front_nxt);
  end

  assign rear_addr = wrap_dec(back_nxt, last);

  cdq_ram #(
    .SLOTS (RING_SLOTS),
    .WIDTH (VALUE_BITS)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (accept),
    .raddr_a (front_nxt),
    .raddr_b (rear_addr),
    .rdata_a (rd_front),
    .rdata_b (rd_rear)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= cdq_pkg::CAP_RESET;
      front_r    <= '0;
      back_r     <= '0;
      valid_r    <= 1'b0;
      accepted_r <= 1'b0;
      empty_r    <= 1'b1;
      full_r     <= 1'b0;
    end else begin
      valid_r <= accept;
      if (cfg_we) begin
        cap_r   <= cfg_capacity;
        front_r <= '0;
        back_r  <= '0;
      end else if (accept) begin
        front_r <= front_nxt;
        back_r  <= back_nxt;
      end
      if (accept) begin
        accepted_r <= ok_nxt;
        empty_r    <= empty_nxt;
        full_r     <= full_nxt;
      end
    end
  end

  assign front_ext = 64'(rd_front);
  assign rear_ext  = 64'(rd_rear);

  assign out_valid       = valid_r;
  assign out_accepted    = accepted_r;
  assign out_now_empty   = empty_r;
  assign out_now_full    = full_r;
  assign out_front_value = empty_r ? '1 : front_ext[cdq_pkg::IO_W-1:0];
  assign out_rear_value  = empty_r ? '1 : rear_ext[cdq_pkg::IO_W-1:0];

endmodule
`default_nettype wire

### src/cdq_ram.sv
// Ring storage of the deque: one write port, two registered read ports.
// A read at the address written in the same cycle returns the new data.
// Depends on nothing outside this file.
`default_nettype none
module cdq_ram #(
  parameter int SLOTS = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(SLOTS)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(SLOTS)-1:0] raddr_a,
  input  wire logic [$clog2(SLOTS)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (raddr_a == waddr)) begin
        rdata_a <= wdata;
      end else begin
        rdata_a <= mem[raddr_a];
      end
      if (we && (raddr_b == waddr)) begin
        rdata_b <= wdata;
      end else begin
        rdata_b <= mem[raddr_b];
      end
    end
  end

endmodule
`default_nettype wire

### verif/circular_deque_top_tb.sv
// Self-checking testbench for circular_deque_top: drives requests and capacity writes,
// and predicts each result with its own deque tracker. Needs cdq_pkg and the
// circular_deque_top RTL with its cdq_ram.
`default_nettype none
module circular_deque_top_tb;

  typedef struct {
    logic                            accepted;
    logic signed [cdq_pkg::IO_W-1:0] front_value;
    logic signed [cdq_pkg::IO_W-1:0] rear_value;
    logic                            now_empty;
    logic                            now_full;
  } deque_status_t;

  class deque_tracker;
    logic [cdq_pkg::CAP_W-1:0] capacity_q;
    logic [cdq_pkg::IO_W-1:0]  ring [cdq_pkg::RING_SLOTS_DEF];
    int                        front_ptr;
    int                        back_ptr;
    deque_status_t             expected_q[$];
    int                        errors;
    int                        results_seen;

    function new();
      capacity_q = cdq_pkg::CAP_RESET;
      front_ptr = 0;
      back_ptr = 0;
      foreach (ring[i]) ring[i] = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function int slots();
      int s;
      s = int'(capacity_q) + 1;
      return (s > cdq_pkg::RING_SLOTS_DEF) ? cdq_pkg::RING_SLOTS_DEF : s;
    endfunction

    function int next_slot(int p);
      return (p + 1 >= slots()) ? 0 : p + 1;
    endfunction

    function int prev_slot(int p);
      return (p == 0) ? slots() - 1 : p - 1;
    endfunction

    function bit is_empty();
      return front_ptr == back_ptr;
    endfunction

    function bit is_full();
      return next_slot(back_ptr) == front_ptr;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_capacity(logic [cdq_pkg::CAP_W-1:0] c);
      capacity_q = c;
      front_ptr = 0;
      back_ptr = 0;
    endfunction

    task report_mismatch(string what, logic [cdq_pkg::IO_W-1:0] got,
                         logic [cdq_pkg::IO_W-1:0] want);
      $display("MISMATCH result %0d: %s got %h want %h", results_seen, what, got, want);
      errors++;
    endtask

    task note_request(logic [cdq_pkg::OP_W-1:0] op, logic signed [cdq_pkg::IO_W-1:0] value);
      deque_status_t s;
      s.accepted = 1'b0;
      case (op)
        cdq_pkg::OP_PEEK: begin
          s.accepted = 1'b1;
        end
        cdq_pkg::OP_PUSH_FRONT: begin
          if (!is_full()) begin
            front_ptr = prev_slot(front_ptr);
            ring[front_ptr] = value;
            s.accepted = 1'b1;
          end
        end
        cdq_pkg::OP_PUSH_BACK: begin
          if (!is_full()) begin
            ring[back_ptr] = value;
            back_ptr = next_slot(back_ptr);
            s.accepted = 1'b1;
          end
        end
        cdq_pkg::OP_POP_FRONT: begin
          if (!is_empty()) begin
            front_ptr = next_slot(front_ptr);
            s.accepted = 1'b1;
          end
        end
        cdq_pkg::OP_POP_BACK: begin
          if (!is_empty()) begin
            back_ptr = prev_slot(back_ptr);
            s.accepted = 1'b1;
          end
        end
        default: ;
      endcase
      s.now_empty = is_empty();
      s.now_full = is_full();
      s.front_value = s.now_empty ? -1 : ring[front_ptr];
      s.rear_value = s.now_empty ? -1 : ring[prev_slot(back_ptr)];
      expected_q.push_back(s);
    endtask

    task check_result(logic acc, logic signed [cdq_pkg::IO_W-1:0] fv,
                      logic signed [cdq_pkg::IO_W-1:0] rv, logic emp, logic ful);
      deque_status_t w;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request pending", {31'd0, acc}, '0);
      end else begin
        w = expected_q.pop_front();
        if (acc !== w.accepted) report_mismatch("accepted", {31'd0, acc}, {31'd0, w.accepted});
        if (fv !== w.front_value) report_mismatch("front_value", fv, w.front_value);
        if (rv !== w.rear_value) report_mismatch("rear_value", rv, w.rear_value);
        if (emp !== w.now_empty) report_mismatch("now_empty", {31'd0, emp}, {31'd0, w.now_empty});
        if (ful !== w.now_full) report_mismatch("now_full", {31'd0, ful}, {31'd0, w.now_full});
      end
    endtask
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  logic [cdq_pkg::OP_W-1:0]        in_operation;
  logic signed [cdq_pkg::IO_W-1:0] in_push_value;
  logic                            cfg_we;
  logic [cdq_pkg::CAP_W-1:0]       cfg_capacity;
  logic                            out_valid;
  logic                            out_accepted;
  logic signed [cdq_pkg::IO_W-1:0] out_front_value;
  logic signed [cdq_pkg::IO_W-1:0] out_rear_value;
  logic                            out_now_empty;
  logic                            out_now_full;

  deque_tracker tracker = new();
  int push_pct = 80;

  circular_deque_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_operation(in_operation),
    .in_push_value(in_push_value),
    .cfg_we(cfg_we),
    .cfg_capacity(cfg_capacity),
    .out_valid(out_valid),
    .out_accepted(out_accepted),
    .out_front_value(out_front_value),
    .out_rear_value(out_rear_value),
    .out_now_empty(out_now_empty),
    .out_now_full(out_now_full)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1)
        tracker.check_result(out_accepted, out_front_value, out_rear_value,
                             out_now_empty, out_now_full);
      if (start && busy === 1'b0) tracker.note_request(in_operation, in_push_value);
      if (cfg_we) tracker.set_capacity(cfg_capacity);
    end
  end

  task send(logic [cdq_pkg::OP_W-1:0] op, logic [cdq_pkg::IO_W-1:0] value);
    @(negedge clk);
    start = 1'b1;
    in_operation = op;
    in_push_value = value;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // start drops here; noise on the request fields while idle
  task pause(int n);
    @(negedge clk);
    start = 1'b0;
    in_operation = cdq_pkg::OP_W'($urandom);
    in_push_value = $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  task drain();
    pause(1);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task write_capacity(logic [cdq_pkg::CAP_W-1:0] c);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_capacity = c;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_capacity = cdq_pkg::CAP_W'($urandom);
  endtask

  function logic [cdq_pkg::IO_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function logic [cdq_pkg::OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 4) return cdq_pkg::OP_W'($urandom_range(7, 5));
    if (r < 12) return cdq_pkg::OP_PEEK;
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_BACK;
    return $urandom_range(1) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_BACK;
  endfunction

  task send_random(int idle_pct);
    if (tracker.is_full()) push_pct = 20;
    else if (tracker.is_empty()) push_pct = 80;
    else if ($urandom_range(99) < 5) push_pct = 100 - push_pct;
    send(pick_op(), pick_value());
    while ($urandom_range(99) < idle_pct) pause(1);
  endtask

  initial begin
    logic [cdq_pkg::CAP_W-1:0] caps [9];
    int idle_mode [3];
    int seg;
    caps = '{4'd1, 4'd15, 4'd7, 4'd0, 4'd3, 4'd15, 4'd2, 4'd12, 4'd15};
    idle_mode = '{22, 64, 0};
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = cdq_pkg::OP_PEEK;
    in_push_value = '0;
    cfg_we = 1'b0;
    cfg_capacity = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset capacity: empty refusals, extremes, unknown codes
    send(cdq_pkg::OP_POP_FRONT, 32'h1234_5678);
    send(cdq_pkg::OP_POP_BACK, 32'h0);
    send(cdq_pkg::OP_PEEK, 32'hffff_ffff);
    send(cdq_pkg::OP_PUSH_BACK, 32'h7fff_ffff);
    send(cdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    send(cdq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
    send(cdq_pkg::OP_PUSH_BACK, 32'hffff_ffff);
    send(cdq_pkg::OP_PEEK, 32'h5555_5555);
    send(3'd5, 32'haaaa_aaaa);
    send(3'd6, 32'h1);
    send(3'd7, 32'h8000_0001);
    send(cdq_pkg::OP_POP_FRONT, 32'h0);
    send(cdq_pkg::OP_POP_BACK, 32'h0);
    send(cdq_pkg::OP_POP_BACK, 32'h0);
    send(cdq_pkg::OP_POP_FRONT, 32'h0);
    send(cdq_pkg::OP_POP_FRONT, 32'h0);

    // small ring: full refusals
    write_capacity(4'd2);
    send(cdq_pkg::OP_PUSH_BACK, 32'h1);
    send(cdq_pkg::OP_PUSH_FRONT, 32'h2);
    send(cdq_pkg::OP_PUSH_BACK, 32'h3);
    send(cdq_pkg::OP_PUSH_FRONT, 32'h4);
    send(cdq_pkg::OP_PEEK, 32'h0);
    send(cdq_pkg::OP_POP_BACK, 32'h0);
    send(cdq_pkg::OP_POP_FRONT, 32'h0);
    send(cdq_pkg::OP_POP_FRONT, 32'h0);

    for (seg = 0; seg < 9; seg++) begin
      write_capacity(caps[seg]);
      push_pct = 80;
      for (int i = 0; i < 125; i++) begin
        if (i == 60 && $urandom_range(1)) drain();
        send_random(idle_mode[seg / 3]);
      end
    end

    pause(1);
    for (int i = 0; i < 1000 && tracker.pending() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report_mismatch("results never arrived", tracker.pending(), '0);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TIMEOUT");
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire

### files.f
src/cdq_pkg.sv
src/cdq_ram.sv
src/circular_deque_top.sv
verif/circular_deque_top_tb.sv
